[rtl/core/smap_pkg.sv]
// Shared constants and types for the mapped address parser.
package smap_pkg;

    localparam int MAX_MESSAGE_BYTES_DEF = 512;

    localparam int          HEADER_BYTES = 20;
    localparam logic [15:0] MAPPED_KIND  = 16'h0020;
    localparam logic [15:0] PORT_MASK    = 16'h2112;
    localparam logic [31:0] ADDR_MASK    = 32'h2112_A442;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_ATTR   = 2'd1;
    localparam logic [1:0] PH_VALUE  = 2'd2;
    localparam logic [1:0] PH_SKIP   = 2'd3;

    typedef struct packed {
        logic        found;
        logic [15:0] mapped_port;
        logic [31:0] mapped_address;
    } t_result;

endpackage

[rtl/core/smap_in_if.sv]
// Byte channel carrying the received message.
interface smap_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       end_of_msg;

    modport source (output valid, output msg_byte, output end_of_msg, input ready);
    modport sink   (input valid, input msg_byte, input end_of_msg, output ready);
endinterface

[rtl/core/smap_out_if.sv]
// Result channel carrying the decoded mapped address.
interface smap_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] mapped_port;
    logic [31:0] mapped_address;

    modport source (output valid, output found, output mapped_port,
                    output mapped_address, input ready);
    modport sink   (input valid, input found, input mapped_port,
                    input mapped_address, output ready);
endinterface

[rtl/core/stun_mapped_address_parser.sv]
// Top level: byte-serial STUN response parser extracting the mapped address.
//
// Usage:
//   i_in  takes one message byte per word, end_of_msg set on the final byte.
//   o_res gives one word per message, on its final byte: found, port and
//   IPv4 address with the XOR masks removed (zero when not found).
//   Each byte updates the parse state in the cycle it is accepted; a new
//   byte can be taken every cycle while ready is high, so throughput is
//   one byte per cycle; a final byte's result is registered on o_res.
//   A two-entry result buffer (output register plus skid register) sits on
//   o_res; i_in deasserts ready only while both entries are full, i.e. when
//   the receiver stalls across two pending results.
//   Bytes beyond MAX_MESSAGE_BYTES are accepted but not parsed.
//   Reset (synchronous, active low) returns the parser to the header phase
//   and empties the result buffer. The parser also restarts after each
//   final byte.
module stun_mapped_address_parser #(
    parameter int MAX_MESSAGE_BYTES = smap_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smap_in_if.sink     i_in,
    smap_out_if.source  o_res
);

    localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [1:0]       r_phase, n_phase;
    logic [2:0]       r_cnt, n_cnt;
    logic [15:0]      r_kind, n_kind;
    logic [15:0]      r_left, n_left;
    logic [15:0]      r_port, n_port;
    logic [31:0]      r_addr, n_addr;
    logic             r_match, n_match;
    logic             r_capt, n_capt;

    smap_pkg::t_result r_out, r_skid, res;
    logic              r_out_valid, r_skid_valid;

    logic accept, emit, ok;
    logic [7:0] b;

    assign i_in.ready = !r_skid_valid;
    assign accept     = i_in.valid && i_in.ready;
    assign emit       = accept && i_in.end_of_msg;
    assign b          = i_in.msg_byte;

    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_kind  = r_kind;
        n_left  = r_left;
        n_port  = r_port;
        n_addr  = r_addr;
        n_match = r_match;
        n_capt  = r_capt;
        ok      = 1'b0;
        res     = '0;
        if (accept) begin
            if (r_pos < POS_W'(MAX_MESSAGE_BYTES)) begin
                n_pos = r_pos + POS_W'(1);
                unique case (r_phase)
                    smap_pkg::PH_HEADER: begin
                        if (r_pos >= POS_W'(smap_pkg::HEADER_BYTES - 1)) begin
                            n_phase = smap_pkg::PH_ATTR;
                            n_cnt   = 3'd0;
                        end
                    end
                    smap_pkg::PH_ATTR: begin
                        if (r_cnt < 3'd2) begin
                            n_kind = {r_kind[7:0], b};
                        end else begin
                            n_left = {r_left[7:0], b};
                        end
                        if (r_cnt >= 3'd3) begin
                            n_cnt = 3'd0;
                            if (n_kind == smap_pkg::MAPPED_KIND) begin
                                n_match = 1'b1;
                                n_phase = smap_pkg::PH_VALUE;
                            end else if (n_left != 16'd0) begin
                                n_phase = smap_pkg::PH_SKIP;
                            end
                        end else begin
                            n_cnt = r_cnt + 3'd1;
                        end
                    end
                    smap_pkg::PH_VALUE: begin
                        if (r_left != 16'd0) begin
                            n_left = r_left - 16'd1;
                        end
                        if (!r_capt) begin
                            if (r_cnt == 3'd2 || r_cnt == 3'd3) begin
                                n_port = {r_port[7:0], b};
                            end else if (r_cnt >= 3'd4) begin
                                n_addr = {r_addr[23:0], b};
                            end
                            if (r_cnt >= 3'd7) begin
                                n_capt = 1'b1;
                            end else begin
                                n_cnt = r_cnt + 3'd1;
                            end
                        end
                    end
                    default: begin
                        if (r_left != 16'd0) begin
                            n_left = r_left - 16'd1;
                        end
                        if (n_left == 16'd0) begin
                            n_phase = smap_pkg::PH_ATTR;
                        end
                    end
                endcase
            end
            if (i_in.end_of_msg) begin
                ok = n_match && n_capt && (n_left == 16'd0);
                res.found          = ok;
                res.mapped_port    = ok ? (n_port ^ smap_pkg::PORT_MASK) : 16'd0;
                res.mapped_address = ok ? (n_addr ^ smap_pkg::ADDR_MASK) : 32'd0;
                n_pos   = '0;
                n_phase = smap_pkg::PH_HEADER;
                n_cnt   = 3'd0;
                n_kind  = 16'd0;
                n_left  = 16'd0;
                n_port  = 16'd0;
                n_addr  = 32'd0;
                n_match = 1'b0;
                n_capt  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= smap_pkg::PH_HEADER;
            r_cnt   <= 3'd0;
            r_kind  <= 16'd0;
            r_left  <= 16'd0;
            r_port  <= 16'd0;
            r_addr  <= 32'd0;
            r_match <= 1'b0;
            r_capt  <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_kind  <= n_kind;
            r_left  <= n_left;
            r_port  <= n_port;
            r_addr  <= n_addr;
            r_match <= n_match;
            r_capt  <= n_capt;
        end
    end

    // result buffer: output register backed by a skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && o_res.ready) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (emit) begin
                r_out <= res;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (emit) begin
            if (!r_out_valid) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.found          = r_out.found;
    assign o_res.mapped_port    = r_out.mapped_port;
    assign o_res.mapped_address = r_out.mapped_address;

endmodule

[tb/smap_checker.sv]
// Mapped address parser checker: predicts each result word from the accepted bytes and compares.
module smap_checker #(
    parameter int MAX_BYTES = smap_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    smap_in_if   i_msg_mon,
    smap_out_if  i_res_mon,
    output int   o_fail_count,
    output int   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import smap_pkg::*;

    logic [15:0] msg_pos;
    logic [1:0]  parse_ph;
    logic [2:0]  field_idx;
    logic [15:0] attr_kind;
    logic [15:0] attr_left;
    logic [15:0] port_acc;
    logic [31:0] addr_acc;
    logic        match_hit;
    logic        value_done;

    t_result expected_decodes[$];
    int      fail_total = 0;

    task automatic restart_parse();
        msg_pos    = '0;
        parse_ph   = PH_HEADER;
        field_idx  = '0;
        attr_kind  = '0;
        attr_left  = '0;
        port_acc   = '0;
        addr_acc   = '0;
        match_hit  = 1'b0;
        value_done = 1'b0;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        case (parse_ph)
            PH_HEADER: begin
                if (int'(msg_pos) + 1 >= HEADER_BYTES) begin
                    parse_ph  = PH_ATTR;
                    field_idx = '0;
                end
            end
            PH_ATTR: begin
                if (field_idx < 2)
                    attr_kind = {attr_kind[7:0], b};
                else
                    attr_left = {attr_left[7:0], b};
                if (field_idx >= 3) begin
                    field_idx = '0;
                    if (attr_kind == MAPPED_KIND) begin
                        match_hit = 1'b1;
                        parse_ph  = PH_VALUE;
                    end else if (attr_left != 0) begin
                        parse_ph = PH_SKIP;
                    end
                end else begin
                    field_idx = field_idx + 1'b1;
                end
            end
            PH_VALUE: begin
                if (attr_left != 0)
                    attr_left = attr_left - 1'b1;
                if (!value_done) begin
                    if (field_idx == 2 || field_idx == 3)
                        port_acc = {port_acc[7:0], b};
                    else if (field_idx >= 4)
                        addr_acc = {addr_acc[23:0], b};
                    if (field_idx >= 7)
                        value_done = 1'b1;
                    else
                        field_idx = field_idx + 1'b1;
                end
            end
            default: begin
                if (attr_left != 0)
                    attr_left = attr_left - 1'b1;
                if (attr_left == 0)
                    parse_ph = PH_ATTR;
            end
        endcase
    endtask

    initial restart_parse();

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        bit      ok;
        if (!i_rst_n) begin
            restart_parse();
            expected_decodes.delete();
        end else begin
            if (i_msg_mon.valid && i_msg_mon.ready) begin
                if (int'(msg_pos) < MAX_BYTES) begin
                    parse_byte(i_msg_mon.msg_byte);
                    msg_pos = msg_pos + 1'b1;
                end
                if (i_msg_mon.end_of_msg) begin
                    ok = match_hit && value_done && attr_left == 0;
                    want.found          = ok;
                    want.mapped_port    = ok ? port_acc ^ PORT_MASK : '0;
                    want.mapped_address = ok ? addr_acc ^ ADDR_MASK : '0;
                    expected_decodes.push_back(want);
                    restart_parse();
                end
            end
            if (i_res_mon.valid && i_res_mon.ready) begin
                got.found          = i_res_mon.found;
                got.mapped_port    = i_res_mon.mapped_port;
                got.mapped_address = i_res_mon.mapped_address;
                if (expected_decodes.size() == 0) begin
                    $error("result word with none pending: found=%0b port=%h addr=%h",
                           got.found, got.mapped_port, got.mapped_address);
                    fail_total++;
                end else begin
                    want = expected_decodes.pop_front();
                    if (got.found !== want.found) begin
                        $error("found: expected %0b, got %0b", want.found, got.found);
                        fail_total++;
                    end
                    if (got.mapped_port !== want.mapped_port) begin
                        $error("mapped_port: expected %h, got %h",
                               want.mapped_port, got.mapped_port);
                        fail_total++;
                    end
                    if (got.mapped_address !== want.mapped_address) begin
                        $error("mapped_address: expected %h, got %h",
                               want.mapped_address, got.mapped_address);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count  <= fail_total;
        o_outstanding <= expected_decodes.size();
    end

endmodule

[tb/testbench.sv]
// Top of the mapped address parser bench: clock, reset, message stimulus, receiver and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smap_pkg::*;

    localparam int MAX_BYTES    = MAX_MESSAGE_BYTES_DEF;
    localparam int ITEM_TARGET  = 1800;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    smap_in_if  msg_bus ();
    smap_out_if res_bus ();

    int fail_count;
    int outstanding;

    stun_mapped_address_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (msg_bus),
        .o_res   (res_bus)
    );

    smap_checker #(.MAX_BYTES(MAX_BYTES)) decode_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_msg_mon     (msg_bus),
        .i_res_mon     (res_bus),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    logic [7:0] msg_buf[$];
    int         burst_left = 0;
    int         bytes_sent = 0;
    bit         hold_request = 1'b0;
    bit         hold_done = 1'b0;

    function automatic logic [7:0] value_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // any type but the mapped one; often a one-bit near miss
    function automatic logic [15:0] other_kind();
        logic [15:0] k;
        if ($urandom_range(0, 2) == 0)
            k = MAPPED_KIND ^ (16'h1 << $urandom_range(0, 15));
        else
            k = 16'($urandom);
        if (k == MAPPED_KIND)
            k = k ^ 16'h0100;
        return k;
    endfunction

    task automatic add_random(input int n);
        repeat (n) msg_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_attr(input logic [15:0] kind, input logic [15:0] len, input int n_vals);
        msg_buf.push_back(kind[15:8]);
        msg_buf.push_back(kind[7:0]);
        msg_buf.push_back(len[15:8]);
        msg_buf.push_back(len[7:0]);
        repeat (n_vals) msg_buf.push_back(value_byte());
    endtask

    task automatic add_fillers(input int count);
        int len;
        repeat (count) begin
            len = $urandom_range(0, 6);
            add_attr(other_kind(), 16'(len), len);
        end
    endtask

    task automatic send_msg();
        int gap;
        for (int i = 0; i < msg_buf.size(); i++) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    msg_bus.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                         : $urandom_range(1, 30);
            end
            msg_bus.valid      <= 1'b1;
            msg_bus.msg_byte   <= msg_buf[i];
            msg_bus.end_of_msg <= (i == msg_buf.size() - 1);
            @(posedge i_clk);
            while (!msg_bus.ready) @(posedge i_clk);
            burst_left--;
            bytes_sent++;
        end
    endtask

    // receiver: ready pattern changes mode after each random-length span, with one long hold once requested
    initial begin
        int mode;
        int span;
        int tick;
        tick = 0;
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) begin
                    res_bus.ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 60);
            repeat (span) begin
                case (mode)
                    0:       res_bus.ready <= 1'b1;
                    1:       res_bus.ready <= 1'($urandom_range(0, 1));
                    2:       res_bus.ready <= ($urandom_range(0, 3) != 0);
                    default: res_bus.ready <= (tick % 5 == 0);
                endcase
                tick++;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int r;
        int msg_count;
        int k;
        int len;
        msg_count = 0;
        i_rst_n            <= 1'b0;
        msg_bus.valid      <= 1'b0;
        msg_bus.msg_byte   <= 8'h00;
        msg_bus.end_of_msg <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-byte messages at both extremes, then a header-only message
        msg_buf = '{8'hFF};
        send_msg();
        msg_buf = '{8'h00};
        send_msg();
        msg_buf.delete();
        for (int i = 0; i < HEADER_BYTES; i++) msg_buf.push_back(i[0] ? 8'hFF : 8'h00);
        send_msg();

        while (bytes_sent < ITEM_TARGET) begin
            msg_buf.delete();
            if (msg_count == 8 || msg_count == 30) begin
                // oversize: match lands inside, across or beyond the parse bound
                add_random(HEADER_BYTES);
                len = $urandom_range(460, 490);
                add_attr(other_kind(), 16'(len), len);
                add_attr(MAPPED_KIND, 16'd8, 8);
                k = MAX_BYTES + $urandom_range(1, 40);
                while (msg_buf.size() < k) msg_buf.push_back(value_byte());
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    add_random(HEADER_BYTES);
                    add_fillers($urandom_range(0, 2));
                    len = ($urandom_range(0, 2) == 0) ? $urandom_range(9, 14) : 8;
                    add_attr(MAPPED_KIND, 16'(len), len);
                    add_fillers($urandom_range(0, 2));
                end else if (r < 55) begin
                    // declared length below eight
                    add_random(HEADER_BYTES);
                    add_fillers($urandom_range(0, 1));
                    add_attr(MAPPED_KIND, 16'($urandom_range(0, 7)), $urandom_range(5, 12));
                end else if (r < 65) begin
                    // message cut inside the matched value
                    add_random(HEADER_BYTES);
                    add_fillers($urandom_range(0, 2));
                    len = $urandom_range(8, 16);
                    add_attr(MAPPED_KIND, 16'(len), $urandom_range(0, len - 1));
                end else if (r < 75) begin
                    // message cut inside an attribute header
                    add_random(HEADER_BYTES);
                    add_fillers($urandom_range(0, 2));
                    add_attr(($urandom_range(0, 1) != 0) ? MAPPED_KIND : other_kind(),
                             16'd8, 0);
                    k = $urandom_range(1, 3);
                    repeat (4 - k) void'(msg_buf.pop_back());
                end else if (r < 80) begin
                    add_random(HEADER_BYTES);
                    add_fillers($urandom_range(0, 3));
                end else if (r < 88) begin
                    add_random($urandom_range(1, HEADER_BYTES));
                end else begin
                    add_random($urandom_range(1, 64));
                end
            end
            send_msg();
            msg_count++;
            if (bytes_sent > 400)
                hold_request = 1'b1;
        end

        msg_bus.valid      <= 1'b0;
        msg_bus.end_of_msg <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

[sim.f]
rtl/core/smap_pkg.sv
rtl/core/smap_in_if.sv
rtl/core/smap_out_if.sv
rtl/core/stun_mapped_address_parser.sv
tb/smap_checker.sv
tb/testbench.sv
